[hdl/iis_pkg.sv]
// iis_pkg: shared types and fixed constants for the integral image stream
// no dependencies; used by scoped names in the top level, front, back, checker and testbench
package iis_pkg;

    // payload widths fixed by the interface
    localparam int PIXEL_W   = 32;
    localparam int ROW_SUM_W = 44;
    localparam int SUM_W     = 56;
    localparam int DIM_W     = 13;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // register value after reset, before clamping to the build maximum
    localparam int DIM_RESET = 4096;

    // entries of the queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 4;

    // classification of one word by the front
    typedef struct packed {
        logic first_col;
        logic first_row;
        logic last_col;
        logic last_row;
    } ctrl_t;

endpackage

[hdl/integral_image_stream.sv]
// integral_image_stream: streaming summed-area table, top level
// depends on iis_pkg, iis_front, iis_queue, iis_back (and iis_ram below it)
//
// usage
// - pixel words enter on in_valid/in_ready in raster order, one per clock
// - each pixel gives exactly one area_sum word on out_valid/out_ready, with
//   row_end on the last pixel of a row and frame_end on the last of the frame
// - cfg port: index 0 image width, index 1 image height; zero acts as one,
//   values above the build maximum act as the maximum; any write restarts
//   the frame at the top-left corner; write only while the block is idle
// - path: a taken pixel passes through the queue, the stage a registers and the
//   output register before its word is offered
// - throughput: one pixel per clock; the per-pixel loop is one 44-bit add
//   for the row sum, one line store read and write, one 56-bit add
// - line store: one MAX_WIDTH-word memory with registered read; a same-column
//   read behind a pending write is served by a bypass register
// - reset: sizes return to 4096 (clamped), positions to the frame start;
//   the line store needs no clearing since the first row never reads it
// - receiver stall: the output register holds its word; the back part halts,
//   the front keeps filling a four-word queue, then in_ready drops
module integral_image_stream #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [iis_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [iis_pkg::DIM_W-1:0]        cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [iis_pkg::PIXEL_W-1:0]      pixel,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [iis_pkg::SUM_W-1:0]        area_sum,
    output logic                             row_end,
    output logic                             frame_end
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int QW = iis_pkg::PIXEL_W + CW + $bits(iis_pkg::ctrl_t);

    // front to queue
    logic            push_valid;
    logic            push_ready;
    logic [CW-1:0]   push_col;
    iis_pkg::ctrl_t  push_ctrl;
    logic [QW-1:0]   push_data;

    // queue to back
    logic                          q_valid;
    logic                          q_pop;
    logic [QW-1:0]                 q_data;
    logic [iis_pkg::PIXEL_W-1:0]   q_pixel;
    logic [CW-1:0]                 q_col;
    iis_pkg::ctrl_t                q_ctrl;

    // front accepts a word whenever the queue has room
    assign in_ready = push_ready;

    iis_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_col   (push_col),
        .push_ctrl  (push_ctrl)
    );

    // pixel, column and classification travel together through the queue
    assign push_data = {pixel, push_col, push_ctrl};

    iis_queue #(
        .WIDTH (QW),
        .DEPTH (iis_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_data   (q_data)
    );

    assign {q_pixel, q_col, q_ctrl} = q_data;

    iis_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_pixel   (q_pixel),
        .q_col     (q_col),
        .q_ctrl    (q_ctrl),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .area_sum  (area_sum),
        .row_end   (row_end),
        .frame_end (frame_end)
    );

endmodule

[hdl/iis_ram.sv]
// iis_ram: generic single-write, single-read memory with registered read
// no dependencies
module iis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read during write to the same address returns the old contents
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/iis_queue.sv]
// iis_queue: short first-in first-out buffer between front and back
// no dependencies
module iis_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int NW = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [NW-1:0]    count_reg;
    logic [NW-1:0]    count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != NW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hdl/iis_front.sv]
// iis_front: size registers, raster position counters and word classification
// depends on iis_pkg
module iis_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [iis_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [iis_pkg::DIM_W-1:0]        cfg_data,
    input  logic                             in_valid,
    input  logic                             push_ready,
    output logic                             push_valid,
    output logic [CW-1:0]                    push_col,
    output iis_pkg::ctrl_t                   push_ctrl
);

    localparam int W_RESET = (iis_pkg::DIM_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                              : iis_pkg::DIM_RESET;
    localparam int H_RESET = (iis_pkg::DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT
                                                               : iis_pkg::DIM_RESET;

    // sizes are held as last index, already clamped
    logic [CW-1:0] col_last_reg;
    logic [CW-1:0] col_last_next;
    logic [RW-1:0] row_last_reg;
    logic [RW-1:0] row_last_next;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic [31:0]   cfg_wide;
    logic [CW-1:0] cfg_col_last;
    logic [RW-1:0] cfg_row_last;
    logic          cfg_write;
    logic          accept;
    logic          last_col;
    logic          last_row;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign accept    = in_valid && push_ready;
    assign cfg_wide  = 32'(cfg_data);

    // zero acts as one, oversize acts as the maximum
    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_col_last = '0;
            cfg_row_last = '0;
        end
        else
        begin
            cfg_col_last = (cfg_wide > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH - 1)
                                                       : CW'(cfg_wide - 32'd1);
            cfg_row_last = (cfg_wide > 32'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT - 1)
                                                        : RW'(cfg_wide - 32'd1);
        end
    end

    assign last_col = (col_reg == col_last_reg);
    assign last_row = (row_reg == row_last_reg);

    always_comb
    begin
        col_last_next = col_last_reg;
        row_last_next = row_last_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                iis_pkg::REG_IMAGE_WIDTH:  col_last_next = cfg_col_last;
                iis_pkg::REG_IMAGE_HEIGHT: row_last_next = cfg_row_last;
                default:                   col_last_next = col_last_reg;
            endcase
            // any register write restarts the frame
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_last_reg <= CW'(W_RESET - 1);
            row_last_reg <= RW'(H_RESET - 1);
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else
        begin
            col_last_reg <= col_last_next;
            row_last_reg <= row_last_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
        end
    end

    assign push_valid          = in_valid;
    assign push_col            = col_reg;
    assign push_ctrl.first_col = (col_reg == '0);
    assign push_ctrl.first_row = (row_reg == '0);
    assign push_ctrl.last_col  = last_col;
    assign push_ctrl.last_row  = last_row;

endmodule

[hdl/iis_back.sv]
// iis_back: row sum, line store access and output register
// depends on iis_pkg and iis_ram
module iis_back #(
    parameter int MAX_WIDTH = 4096,
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  logic [iis_pkg::PIXEL_W-1:0]   q_pixel,
    input  logic [CW-1:0]                 q_col,
    input  iis_pkg::ctrl_t                q_ctrl,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [iis_pkg::SUM_W-1:0]     area_sum,
    output logic                          row_end,
    output logic                          frame_end
);

    // stage a: line store read in flight, row sum known
    logic                            a_valid_reg;
    logic                            a_valid_next;
    logic [CW-1:0]                   a_col_reg;
    iis_pkg::ctrl_t                  a_ctrl_reg;
    logic [iis_pkg::ROW_SUM_W-1:0]   a_sum_reg;
    logic                            a_byp_reg;
    logic [iis_pkg::SUM_W-1:0]       a_byp_data_reg;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [iis_pkg::SUM_W-1:0]       area_sum_reg;
    logic                            row_end_reg;
    logic                            frame_end_reg;

    logic                            a_moves;
    logic                            a_load;
    logic [iis_pkg::ROW_SUM_W-1:0]   sum_base;
    logic [iis_pkg::ROW_SUM_W-1:0]   sum_new;
    logic [iis_pkg::SUM_W-1:0]       rd_data;
    logic [iis_pkg::SUM_W-1:0]       above;
    logic [iis_pkg::SUM_W-1:0]       area;

    assign a_moves = a_valid_reg && (!out_valid_reg || out_ready);
    assign a_load  = q_valid && (!a_valid_reg || a_moves);
    assign q_pop   = a_load;

    assign sum_base = q_ctrl.first_col ? '0 : a_sum_reg;
    assign sum_new  = sum_base + iis_pkg::ROW_SUM_W'(q_pixel);

    always_comb
    begin
        priority if (a_ctrl_reg.first_row)
        begin
            above = '0;
        end
        else if (a_byp_reg)
        begin
            above = a_byp_data_reg;
        end
        else
        begin
            above = rd_data;
        end
    end

    assign area = iis_pkg::SUM_W'(a_sum_reg) + above;

    iis_ram #(
        .WIDTH (iis_pkg::SUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (a_moves),
        .wr_addr (a_col_reg),
        .wr_data (area),
        .rd_en   (a_load),
        .rd_addr (q_col),
        .rd_data (rd_data)
    );

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (a_load)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_moves)
        begin
            a_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (a_moves)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_col_reg      <= q_col;
            a_ctrl_reg     <= q_ctrl;
            a_sum_reg      <= sum_new;
            // the store write leaving now is not seen by the read issued now
            a_byp_reg      <= a_moves && (a_col_reg == q_col);
            a_byp_data_reg <= area;
        end
        if (a_moves)
        begin
            area_sum_reg  <= area;
            row_end_reg   <= a_ctrl_reg.last_col;
            frame_end_reg <= a_ctrl_reg.last_col && a_ctrl_reg.last_row;
        end
    end

    assign out_valid = out_valid_reg;
    assign area_sum  = area_sum_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

endmodule

[hdl/iis_checker.sv]
// iis_checker: port-level assertions for the integral image stream
// depends on iis_pkg; bound to integral_image_stream at the end of this file
module iis_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             cfg_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [iis_pkg::SUM_W-1:0]        area_sum,
    input logic                             row_end,
    input logic                             frame_end
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(area_sum)
                                    && $stable(row_end) && $stable(frame_end))
        else $error("output word changed while stalled");

    // the frame ends only on a row end
    a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> row_end)
        else $error("frame_end without row_end");

    // configuration port never back-pressures
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("cfg_ready low");

    // no output word leaving reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output word present right after reset");

    // a new output word never appears at the first clock with reset released
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(rst_n))
        else $error("output word appeared during reset release");

endmodule

bind integral_image_stream iis_checker u_checker (.*);

[test/integral_image_stream_tb.sv]
// integral_image_stream_tb: self-checking testbench for the integral image stream
// depends on iis_pkg and integral_image_stream; drives pixels, sizes and back pressure
// and checks every area_sum word against a predictor of the summed-area table
`timescale 1ns / 1ps

module integral_image_stream_tb;

    localparam int MAX_DIM       = 4096;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HOLD_CYCLES   = 64;
    localparam int TAIL_CYCLES   = 10;
    localparam int MODE_GOAL     = 430;
    localparam int PHASE_CAP     = 150;
    localparam int LONG_ITEMS    = 200;
    localparam logic [iis_pkg::DIM_W-1:0] DIM_ALL_ONES = '1;

    // which long frame a random mode carries besides its small frames
    typedef enum int {LONG_NONE, LONG_WIDTH, LONG_HEIGHT} long_frame_t;

    // one expected output word
    typedef struct {
        logic [iis_pkg::SUM_W-1:0] sum;
        logic                      row_last;
        logic                      frame_last;
    } area_word_t;

    // one pending register write
    typedef struct {
        logic [iis_pkg::CFG_INDEX_W-1:0] index;
        logic [iis_pkg::DIM_W-1:0]       data;
    } reg_write_t;

    logic                            clk;
    logic                            rst_n     = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [iis_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [iis_pkg::DIM_W-1:0]       cfg_data  = '0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    logic [iis_pkg::PIXEL_W-1:0]     pixel     = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [iis_pkg::SUM_W-1:0]       area_sum;
    logic                            row_end;
    logic                            frame_end;

    // predictor state: sizes, row accumulator, line of previous sums, position
    logic [iis_pkg::DIM_W-1:0]     width_reg;
    logic [iis_pkg::DIM_W-1:0]     height_reg;
    logic [iis_pkg::ROW_SUM_W-1:0] row_acc;
    logic [iis_pkg::SUM_W-1:0]     line_store [MAX_DIM];
    logic [11:0]                   col_pos;
    logic [11:0]                   row_pos;

    area_word_t area_expect_q [$];
    reg_write_t pending_writes [$];

    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_req;
    int unsigned error_count;
    int unsigned cycle_count;

    integral_image_stream #(
        .MAX_WIDTH  (MAX_DIM),
        .MAX_HEIGHT (MAX_DIM)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel     (pixel),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .area_sum  (area_sum),
        .row_end   (row_end),
        .frame_end (frame_end)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // zero acts as one, anything past the build maximum acts as the maximum
    function automatic int unsigned effective_size(input logic [iis_pkg::DIM_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return 32'(v);
    endfunction

    // any accepted register write sends the frame back to the top-left corner
    task automatic apply_register_write(input logic [iis_pkg::CFG_INDEX_W-1:0] index,
                                        input logic [iis_pkg::DIM_W-1:0] data);
        if (index == iis_pkg::REG_IMAGE_WIDTH)
            width_reg = data;
        else if (index == iis_pkg::REG_IMAGE_HEIGHT)
            height_reg = data;
        else
            return;
        row_acc = '0;
        col_pos = '0;
        row_pos = '0;
    endtask

    // one pixel in, one area word out; also advances the raster position
    task automatic predict_area(input logic [iis_pkg::PIXEL_W-1:0] value);
        int unsigned w;
        int unsigned h;
        logic [11:0] col;
        logic [iis_pkg::SUM_W-1:0] above;
        area_word_t want;
        w = effective_size(width_reg);
        h = effective_size(height_reg);
        col = col_pos;
        above = '0;
        row_acc = row_acc + iis_pkg::ROW_SUM_W'(value);
        // the first row of a frame has nothing above it
        if (row_pos != 0)
            above = line_store[col];
        want.sum = iis_pkg::SUM_W'(row_acc) + above;
        line_store[col] = want.sum;
        want.row_last = (32'(col) + 1 >= w);
        want.frame_last = want.row_last && (32'(row_pos) + 1 >= h);
        area_expect_q = {area_expect_q, want};
        if (want.row_last)
        begin
            row_acc = '0;
            col_pos = '0;
            row_pos = (32'(row_pos) + 1 >= h) ? 12'd0 : row_pos + 12'd1;
        end
        else
        begin
            col_pos = col_pos + 12'd1;
        end
    endtask

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // mix of extremes, small values and full-range random words
    function automatic logic [iis_pkg::PIXEL_W-1:0] random_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    // sends one pixel word; entered and left at a falling edge, valid stays high
    // on return so a caller must either send again or lower it in the same step
    task automatic send_pixel(input logic [iis_pkg::PIXEL_W-1:0] value);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_area(value);
        @(negedge clk);
    endtask

    task automatic send_random_pixels(input int unsigned count);
        repeat (count)
            send_pixel(random_pixel());
    endtask

    task automatic queue_write(input logic [iis_pkg::CFG_INDEX_W-1:0] index,
                               input logic [iis_pkg::DIM_W-1:0] data);
        reg_write_t wr;
        wr.index = index;
        wr.data  = data;
        pending_writes = {pending_writes, wr};
    endtask

    // registers change only with the block idle: stop pixels, let every
    // expected word come back, then issue the queued writes back to back
    task automatic write_registers();
        reg_write_t wr;
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (area_expect_q.size() != 0);
        while (pending_writes.size() != 0)
        begin
            wr = pending_writes.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= wr.index;
            cfg_data  <= wr.data;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            apply_register_write(wr.index, wr.data);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // receiver: random stalls, or a long hold-off when one is requested;
    // the request is sampled at the rising edge so it never races the driver
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // checker: every accepted output word against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : area_checker
        area_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (area_expect_q.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected word, expected none, actual sum %0h row_end %b frame_end %b",
                         $time, area_sum, row_end, frame_end);
            end
            else
            begin
                want = area_expect_q.pop_front();
                if (area_sum !== want.sum)
                begin
                    error_count++;
                    $display("%0t: area_sum mismatch, expected %0h, actual %0h",
                             $time, want.sum, area_sum);
                end
                if (row_end !== want.row_last)
                begin
                    error_count++;
                    $display("%0t: row_end mismatch, expected %b, actual %b",
                             $time, want.row_last, row_end);
                end
                if (frame_end !== want.frame_last)
                begin
                    error_count++;
                    $display("%0t: frame_end mismatch, expected %b, actual %b",
                             $time, want.frame_last, frame_end);
                end
            end
        end
    end

    // run limit, far above the slowest correct run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // sizes after reset are 4096 by 4096: a few words and no row end yet
    task automatic test_reset_sizes();
        repeat (4)
            send_pixel('1);
    endtask

    // zero acts as one: every word ends its row and its frame
    task automatic test_single_pixel_frames();
        queue_write(iis_pkg::REG_IMAGE_WIDTH, '0);
        queue_write(iis_pkg::REG_IMAGE_HEIGHT, '0);
        write_registers();
        send_pixel('1);
        send_pixel('0);
        send_pixel(32'h8000_0001);
    endtask

    // 3 by 2 of full-scale pixels, then the first word of the next frame,
    // which must not read the line store
    task automatic test_small_frame_and_wrap();
        queue_write(iis_pkg::REG_IMAGE_WIDTH, 13'd3);
        queue_write(iis_pkg::REG_IMAGE_HEIGHT, 13'd2);
        write_registers();
        repeat (7)
            send_pixel('1);
    endtask

    // a height write in the middle of row 1 restarts the frame at row 0
    task automatic test_restart_mid_frame();
        queue_write(iis_pkg::REG_IMAGE_WIDTH, 13'd4);
        queue_write(iis_pkg::REG_IMAGE_HEIGHT, 13'd3);
        write_registers();
        send_random_pixels(5);
        queue_write(iis_pkg::REG_IMAGE_HEIGHT, 13'd2);
        write_registers();
        send_random_pixels(4);
    endtask

    // all-ones size values act as the build maximum
    task automatic test_oversize_sizes();
        queue_write(iis_pkg::REG_IMAGE_WIDTH, DIM_ALL_ONES);
        queue_write(iis_pkg::REG_IMAGE_HEIGHT, DIM_ALL_ONES);
        write_registers();
        send_pixel('1);
        send_pixel('1);
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    // words, so the internal queue fills and in_ready has to drop
    task automatic test_output_backpressure();
        int saved_send_pct;
        queue_write(iis_pkg::REG_IMAGE_WIDTH, 13'd5);
        queue_write(iis_pkg::REG_IMAGE_HEIGHT, 13'd4);
        write_registers();
        saved_send_pct = send_idle_pct;
        send_idle_pct  = 0;
        hold_req       = 1'b1;
        send_random_pixels(40);
        send_idle_pct  = saved_send_pct;
    endtask

    // small random sizes, mostly whole frames so frame ends come often
    task automatic random_size_phase(output int unsigned count);
        logic [iis_pkg::DIM_W-1:0] wv;
        logic [iis_pkg::DIM_W-1:0] hv;
        int unsigned n;
        wv = iis_pkg::DIM_W'($urandom_range(0, 12));
        if ($urandom_range(0, 9) == 0)
            hv = iis_pkg::DIM_W'($urandom_range(MAX_DIM + 1, (1 << iis_pkg::DIM_W) - 1));
        else
            hv = iis_pkg::DIM_W'($urandom_range(0, 6));
        case ($urandom_range(0, 3))
            0: queue_write(iis_pkg::REG_IMAGE_WIDTH, wv);
            1: queue_write(iis_pkg::REG_IMAGE_HEIGHT, hv);
            2:
            begin
                queue_write(iis_pkg::REG_IMAGE_WIDTH, wv);
                queue_write(iis_pkg::REG_IMAGE_HEIGHT, hv);
            end
            default:
            begin
                queue_write(iis_pkg::REG_IMAGE_HEIGHT, hv);
                queue_write(iis_pkg::REG_IMAGE_WIDTH, wv);
            end
        endcase
        write_registers();
        n = effective_size(width_reg) * effective_size(height_reg) * $urandom_range(1, 2)
            + $urandom_range(0, effective_size(width_reg));
        // partial frames are fine; a later write restarts anyway
        if (n > PHASE_CAP)
            n = PHASE_CAP;
        send_random_pixels(n);
        count = n;
    endtask

    // one long stretch at the largest height: either wide rows that wrap
    // several times, so later rows read many line store columns, or a
    // one-pixel-wide frame that walks the row counter far down
    task automatic long_frame_phase(input long_frame_t kind);
        logic [iis_pkg::DIM_W-1:0] big;
        if ($urandom_range(0, 1) != 0)
            big = iis_pkg::DIM_W'(MAX_DIM);
        else
            big = iis_pkg::DIM_W'($urandom_range(MAX_DIM, (1 << iis_pkg::DIM_W) - 1));
        if (kind == LONG_WIDTH)
        begin
            queue_write(iis_pkg::REG_IMAGE_WIDTH, iis_pkg::DIM_W'($urandom_range(40, 70)));
            queue_write(iis_pkg::REG_IMAGE_HEIGHT, big);
            write_registers();
            send_random_pixels(LONG_ITEMS);
        end
        else
        begin
            queue_write(iis_pkg::REG_IMAGE_WIDTH, iis_pkg::DIM_W'($urandom_range(0, 1)));
            queue_write(iis_pkg::REG_IMAGE_HEIGHT, big);
            write_registers();
            send_random_pixels(LONG_ITEMS);
        end
    endtask

    task automatic run_random_mode(input int send_pct, input int recv_pct,
                                   input long_frame_t kind);
        int unsigned sent;
        int unsigned count;
        bit long_done;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        long_done = (kind == LONG_NONE);
        while (sent < MODE_GOAL)
        begin
            if (!long_done && sent >= MODE_GOAL / 2)
            begin
                long_frame_phase(kind);
                long_done = 1'b1;
            end
            random_size_phase(count);
            sent += count;
        end
    endtask

    // random traffic in three idling modes
    task automatic test_random_traffic();
        run_random_mode(22, 73, LONG_WIDTH);
        run_random_mode(73, 22, LONG_HEIGHT);
        run_random_mode(0, 0, LONG_NONE);
    endtask

    // stop offering words, wait for every expected word, then a short tail
    task automatic drain_outputs();
        in_valid <= 1'b0;
        while (area_expect_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        error_count   = 0;
        cycle_count   = 0;
        hold_req      = 1'b0;
        send_idle_pct = 22;
        recv_idle_pct = 73;
        // predictor reset state
        width_reg  = iis_pkg::DIM_W'(MAX_DIM);
        height_reg = iis_pkg::DIM_W'(MAX_DIM);
        row_acc    = '0;
        col_pos    = '0;
        row_pos    = '0;

        // hold reset, then release it at a falling edge
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_sizes();
        test_single_pixel_frames();
        test_small_frame_and_wrap();
        test_restart_mid_frame();
        test_oversize_sizes();
        test_output_backpressure();
        test_random_traffic();
        drain_outputs();

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
hdl/iis_pkg.sv
hdl/iis_ram.sv
hdl/iis_queue.sv
hdl/iis_front.sv
hdl/iis_back.sv
hdl/integral_image_stream.sv
hdl/iis_checker.sv
test/integral_image_stream_tb.sv
